### hw/rtl/sia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg: shared types and constants of surface_incidence_angles
// widths of the datapath, register map, arctangent table for the cordic units
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int NODE_W = 24;   // node and surface positions
  localparam int D_W    = 25;   // node minus surface
  localparam int NRM_W  = 16;   // normal, Q2.14
  localparam int A_W    = 17;   // frame x axis
  localparam int B_W    = 34;   // frame y axis
  localparam int PN_W   = D_W + NRM_W;      // d times a normal component
  localparam int PA_W   = D_W + A_W;
  localparam int PB_W   = D_W + B_W;
  localparam int DOT_W  = PN_W + 2;
  localparam int C_W    = PN_W + 1;
  localparam int CORD_W = 62;
  localparam int U_W    = 30;
  localparam int SQ_W   = 62;
  localparam int RES_W  = 31;
  localparam int SH_MAX = DOT_W - U_W;
  localparam int SH_W   = $clog2(SH_MAX + 1);
  localparam int ANG_W  = 16;
  localparam int INC_W  = 14;
  localparam int Z_W    = 28;
  localparam int Q_SHIFT = 11;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int SQRT_STEPS = 31;
  localparam int CORD_LAT   = ANGLE_ITERATIONS + 2;

  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [Z_W-1:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [Z_W-1:0] ROUND_Q24   = 28'sd1024;
  localparam logic [A_W-1:0]        REF_SWITCH  = 17'd14745;

  localparam int ANG_MAX = 25736;
  localparam int INC_MAX = 12868;

  localparam int MQ_DEPTH = 4;
  localparam int MQ_AW    = 2;
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = 1;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_SURFACE_X = 3'd0,
    REG_SURFACE_Y = 3'd1,
    REG_SURFACE_Z = 3'd2,
    REG_NORMAL_X  = 3'd3,
    REG_NORMAL_Y  = 3'd4,
    REG_NORMAL_Z  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [NODE_W-1:0] x;
    logic signed [NODE_W-1:0] y;
    logic signed [NODE_W-1:0] z;
  } node_t;

  typedef struct packed {
    logic signed [NODE_W-1:0] sx;
    logic signed [NODE_W-1:0] sy;
    logic signed [NODE_W-1:0] sz;
    logic signed [NRM_W-1:0]  nx;
    logic signed [NRM_W-1:0]  ny;
    logic signed [NRM_W-1:0]  nz;
    logic signed [A_W-1:0]    ax;
    logic signed [A_W-1:0]    ay;
    logic signed [A_W-1:0]    az;
    logic signed [B_W-1:0]    bx;
    logic signed [B_W-1:0]    by;
    logic signed [B_W-1:0]    bz;
  } cfg_t;

  typedef struct packed {
    logic                    valid_res;
    logic signed [ANG_W-1:0] azimuth;
    logic [INC_W-1:0]        inclination;
  } res_t;

  // atan(2^-i) in Q24 radians
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/sia_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_cfg: configuration registers
// apb register file for surface position and normal, plus the local frame axes
// ----------------------------------------------------------------------------
module sia_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [sia_pkg::APB_AW-1:0]    paddr_i,
  input  logic [sia_pkg::APB_DW-1:0]    pwdata_i,
  output logic [sia_pkg::APB_DW-1:0]    prdata_o,
  output sia_pkg::cfg_t                 cfg_o
);

  logic signed [sia_pkg::NODE_W-1:0] sx_q, sy_q, sz_q;
  logic signed [sia_pkg::NRM_W-1:0]  nx_q, ny_q, nz_q;
  logic signed [sia_pkg::A_W-1:0]    ax_d, ay_d, az_d, ax_q, ay_q, az_q;
  logic signed [sia_pkg::B_W-1:0]    bx_d, by_d, bz_d, bx_q, by_q, bz_q;
  logic signed [sia_pkg::A_W+sia_pkg::NRM_W-1:0] t0, t1, t2, t3, t4, t5;
  logic [sia_pkg::A_W-1:0]           nz_mag;
  logic [2:0]                        idx;
  logic                              wr_en;

  assign idx   = paddr_i[sia_pkg::APB_AW-1:2];
  assign wr_en = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      sz_q <= '0;
      nx_q <= 16'sd16384;
      ny_q <= '0;
      nz_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        sia_pkg::REG_SURFACE_X: sx_q <= pwdata_i[sia_pkg::NODE_W-1:0];
        sia_pkg::REG_SURFACE_Y: sy_q <= pwdata_i[sia_pkg::NODE_W-1:0];
        sia_pkg::REG_SURFACE_Z: sz_q <= pwdata_i[sia_pkg::NODE_W-1:0];
        sia_pkg::REG_NORMAL_X:  nx_q <= pwdata_i[sia_pkg::NRM_W-1:0];
        sia_pkg::REG_NORMAL_Y:  ny_q <= pwdata_i[sia_pkg::NRM_W-1:0];
        sia_pkg::REG_NORMAL_Z:  nz_q <= pwdata_i[sia_pkg::NRM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sia_pkg::REG_SURFACE_X: prdata_o = sia_pkg::APB_DW'(sx_q);
      sia_pkg::REG_SURFACE_Y: prdata_o = sia_pkg::APB_DW'(sy_q);
      sia_pkg::REG_SURFACE_Z: prdata_o = sia_pkg::APB_DW'(sz_q);
      sia_pkg::REG_NORMAL_X:  prdata_o = sia_pkg::APB_DW'(nx_q);
      sia_pkg::REG_NORMAL_Y:  prdata_o = sia_pkg::APB_DW'(ny_q);
      sia_pkg::REG_NORMAL_Z:  prdata_o = sia_pkg::APB_DW'(nz_q);
      default:                prdata_o = '0;
    endcase
  end

  // frame x axis from the reference axis, y axis = n x a
  always_comb begin
    nz_mag = nz_q[sia_pkg::NRM_W-1] ? -sia_pkg::A_W'(nz_q) : sia_pkg::A_W'(nz_q);
    if (nz_mag > sia_pkg::REF_SWITCH) begin
      ax_d = '0;
      ay_d = -sia_pkg::A_W'(nz_q);
      az_d = sia_pkg::A_W'(ny_q);
    end else begin
      ax_d = -sia_pkg::A_W'(ny_q);
      ay_d = sia_pkg::A_W'(nx_q);
      az_d = '0;
    end
  end

  assign t0 = ny_q * az_d;
  assign t1 = nz_q * ay_d;
  assign t2 = nz_q * ax_d;
  assign t3 = nx_q * az_d;
  assign t4 = nx_q * ay_d;
  assign t5 = ny_q * ax_d;
  assign bx_d = sia_pkg::B_W'(t0) - sia_pkg::B_W'(t1);
  assign by_d = sia_pkg::B_W'(t2) - sia_pkg::B_W'(t3);
  assign bz_d = sia_pkg::B_W'(t4) - sia_pkg::B_W'(t5);

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    ay_q <= ay_d;
    az_q <= az_d;
    bx_q <= bx_d;
    by_q <= by_d;
    bz_q <= bz_d;
  end

  assign cfg_o = '{sx: sx_q, sy: sy_q, sz: sz_q, nx: nx_q, ny: ny_q, nz: nz_q,
                   ax: ax_q, ay: ay_q, az: az_q, bx: bx_q, by: by_q, bz: bz_q};

endmodule

### hw/rtl/sia_intake.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_intake: front end
// accepts node positions and queues them for the arithmetic back end
// ----------------------------------------------------------------------------
module sia_intake (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sia_pkg::node_t node_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sia_pkg::node_t head_o
);

  sia_pkg::node_t             mq_q [sia_pkg::MQ_DEPTH];
  logic [sia_pkg::MQ_AW-1:0]  wr_q, rd_q;
  logic [sia_pkg::MQ_AW:0]    cnt_q;
  logic                       push_ok, pop_ok;

  assign full_o  = (cnt_q == (sia_pkg::MQ_AW+1)'(sia_pkg::MQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign head_o  = mq_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) wr_q <= wr_q + 1'b1;
      if (pop_ok)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (sia_pkg::MQ_AW+1)'(push_ok) - (sia_pkg::MQ_AW+1)'(pop_ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) mq_q[wr_q] <= node_i;
  end

endmodule

### hw/rtl/sia_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_cordic: pipelined vectoring cordic
// atan2(y, x) in Q3.13 radians, one rotation per stage
// ----------------------------------------------------------------------------
module sia_cordic (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [sia_pkg::CORD_W-1:0]   xv_i,
  input  logic signed [sia_pkg::CORD_W-1:0]   yv_i,
  output logic signed [sia_pkg::ANG_W-1:0]    angle_o
);

  localparam int N = sia_pkg::ANGLE_ITERATIONS;

  logic signed [sia_pkg::CORD_W-1:0] x_q [N+1];
  logic signed [sia_pkg::CORD_W-1:0] y_q [N+1];
  logic signed [sia_pkg::Z_W-1:0]    z_q [N+1];
  logic                              xneg_q [N+1];
  logic                              yneg_q [N+1];
  logic                              zero_q [N+1];
  logic signed [sia_pkg::CORD_W-1:0] x_d [N];
  logic signed [sia_pkg::CORD_W-1:0] y_d [N];
  logic signed [sia_pkg::Z_W-1:0]    z_d [N];
  logic signed [sia_pkg::CORD_W-1:0] sx_c [N];
  logic signed [sia_pkg::CORD_W-1:0] sy_c [N];
  logic signed [sia_pkg::Z_W-1:0]    zc, zr;
  logic signed [sia_pkg::ANG_W-1:0]  q, angle_q;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      sx_c[i] = x_q[i] >>> i;
      sy_c[i] = y_q[i] >>> i;
      if (y_q[i] > 0) begin
        x_d[i] = x_q[i] + sy_c[i];
        y_d[i] = y_q[i] - sx_c[i];
        z_d[i] = z_q[i] + sia_pkg::atan_q24(sia_pkg::ATAN_IDX_W'(i));
      end else begin
        x_d[i] = x_q[i] - sy_c[i];
        y_d[i] = y_q[i] + sx_c[i];
        z_d[i] = z_q[i] - sia_pkg::atan_q24(sia_pkg::ATAN_IDX_W'(i));
      end
    end
  end

  // clamp to the first quadrant, mirror, round to Q3.13, apply sign of y
  always_comb begin
    if (z_q[N] < 0) begin
      zc = '0;
    end else if (z_q[N] > sia_pkg::HALF_PI_Q24) begin
      zc = sia_pkg::HALF_PI_Q24;
    end else begin
      zc = z_q[N];
    end
    if (xneg_q[N]) zc = sia_pkg::PI_Q24 - zc;
    zr = zc + sia_pkg::ROUND_Q24;
    q  = sia_pkg::ANG_W'(zr >>> sia_pkg::Q_SHIFT);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= xv_i[sia_pkg::CORD_W-1] ? -xv_i : xv_i;
      y_q[0]    <= yv_i[sia_pkg::CORD_W-1] ? -yv_i : yv_i;
      z_q[0]    <= '0;
      xneg_q[0] <= xv_i[sia_pkg::CORD_W-1];
      yneg_q[0] <= yv_i[sia_pkg::CORD_W-1];
      zero_q[0] <= (xv_i == '0) && (yv_i == '0);
      for (int i = 0; i < N; i++) begin
        x_q[i+1]    <= x_d[i];
        y_q[i+1]    <= y_d[i];
        z_q[i+1]    <= z_d[i];
        xneg_q[i+1] <= xneg_q[i];
        yneg_q[i+1] <= yneg_q[i];
        zero_q[i+1] <= zero_q[i];
      end
      if (zero_q[N]) begin
        angle_q <= '0;
      end else begin
        angle_q <= yneg_q[N] ? -q : q;
      end
    end
  end

  assign angle_o = angle_q;

endmodule

### hw/rtl/sia_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_back: arithmetic back end
// dot and cross products, magnitude by square root, two cordic units, result queue
// ----------------------------------------------------------------------------
module sia_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sia_pkg::cfg_t  cfg_i,
  input  logic           q_empty_i,
  input  sia_pkg::node_t q_head_i,
  output logic           q_pop_o,
  output logic           res_empty_o,
  input  logic           res_pop_i,
  output sia_pkg::res_t  res_o
);

  localparam int SUM_STG  = 10;
  localparam int SQRT_END = SUM_STG + sia_pkg::SQRT_STEPS;
  localparam int LAST     = SQRT_END + sia_pkg::CORD_LAT;
  localparam int AZ_STG   = 4 + sia_pkg::CORD_LAT;
  localparam int XS_LEN   = SQRT_END - 8;
  localparam int AZ_LEN   = LAST - AZ_STG - 1;
  localparam int POS_LEN  = LAST - 5;
  localparam int NS       = sia_pkg::SQRT_STEPS;

  logic adv;
  logic vld_q [1:LAST];

  sia_pkg::node_t n1_q;
  logic signed [sia_pkg::D_W-1:0]    dx2_q, dy2_q, dz2_q;
  logic signed [sia_pkg::PN_W-1:0]   pn3_q [3];
  logic signed [sia_pkg::PA_W-1:0]   pa3_q [3];
  logic signed [sia_pkg::PB_W-1:0]   pb3_q [3];
  logic signed [sia_pkg::PN_W-1:0]   pc3_q [6];
  logic signed [sia_pkg::DOT_W-1:0]  dot4_q;
  logic signed [sia_pkg::CORD_W-1:0] fx4_q, fy4_q;
  logic signed [sia_pkg::C_W-1:0]    c4_q [3];
  logic [2:0][sia_pkg::C_W-1:0]      cm5_q, cm6_q, cm7_q;
  logic [sia_pkg::DOT_W-1:0]         dm5_q, dm6_q, dm7_q, m6_q, m_a, m_b;
  logic [sia_pkg::SH_W-1:0]          s7_q, s_c;
  logic [sia_pkg::U_W-1:0]           u8_q [3];
  logic [2*sia_pkg::U_W-1:0]         sq9_q [3];
  logic [sia_pkg::U_W-1:0]           xs_q [XS_LEN+1];
  logic                              pos_q [POS_LEN+1];
  logic signed [sia_pkg::ANG_W-1:0]  az_q [AZ_LEN+1];
  logic [sia_pkg::SQ_W-1:0]          sv_q [NS+1];
  logic [sia_pkg::SQ_W-1:0]          sr_q [NS+1];
  logic [sia_pkg::SQ_W-1:0]          sv_d [NS];
  logic [sia_pkg::SQ_W-1:0]          sr_d [NS];
  logic [sia_pkg::SQ_W-1:0]          sb_c [NS];
  logic [sia_pkg::SQ_W-1:0]          st_c [NS];
  logic signed [sia_pkg::ANG_W-1:0]  az_ang, inc_ang;
  logic signed [sia_pkg::CORD_W-1:0] inc_x, inc_y;

  sia_pkg::res_t             oq_q [sia_pkg::OQ_DEPTH];
  sia_pkg::res_t             res_d;
  logic [sia_pkg::OQ_AW-1:0] oq_wr_q, oq_rd_q;
  logic [sia_pkg::OQ_AW:0]   oq_cnt_q;
  logic                      oq_push, oq_pop;

  // the whole pipeline moves while the result queue has room
  assign adv     = (oq_cnt_q != (sia_pkg::OQ_AW+1)'(sia_pkg::OQ_DEPTH));
  assign q_pop_o = adv && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= LAST; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[1] <= !q_empty_i;
      for (int k = 2; k <= LAST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // largest magnitude and the shift that brings it below 2^30
  always_comb begin
    m_a = (dm5_q > sia_pkg::DOT_W'(cm5_q[0])) ? dm5_q : sia_pkg::DOT_W'(cm5_q[0]);
    m_b = (cm5_q[1] > cm5_q[2]) ? sia_pkg::DOT_W'(cm5_q[1]) : sia_pkg::DOT_W'(cm5_q[2]);
    s_c = '0;
    for (int k = 1; k <= sia_pkg::SH_MAX; k++) begin
      if ((m6_q >> (sia_pkg::U_W - 1 + k)) != '0) s_c = sia_pkg::SH_W'(k);
    end
  end

  // restoring square root, one result bit per stage
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      sb_c[k] = sia_pkg::SQ_W'(1) << (2 * (NS - 1 - k));
      st_c[k] = sr_q[k] + sb_c[k];
      if (sv_q[k] >= st_c[k]) begin
        sv_d[k] = sv_q[k] - st_c[k];
        sr_d[k] = (sr_q[k] >> 1) + sb_c[k];
      end else begin
        sv_d[k] = sv_q[k];
        sr_d[k] = sr_q[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q  <= q_head_i;
      dx2_q <= sia_pkg::D_W'(n1_q.x) - sia_pkg::D_W'(cfg_i.sx);
      dy2_q <= sia_pkg::D_W'(n1_q.y) - sia_pkg::D_W'(cfg_i.sy);
      dz2_q <= sia_pkg::D_W'(n1_q.z) - sia_pkg::D_W'(cfg_i.sz);

      pn3_q[0] <= dx2_q * cfg_i.nx;
      pn3_q[1] <= dy2_q * cfg_i.ny;
      pn3_q[2] <= dz2_q * cfg_i.nz;
      pa3_q[0] <= dx2_q * cfg_i.ax;
      pa3_q[1] <= dy2_q * cfg_i.ay;
      pa3_q[2] <= dz2_q * cfg_i.az;
      pb3_q[0] <= dx2_q * cfg_i.bx;
      pb3_q[1] <= dy2_q * cfg_i.by;
      pb3_q[2] <= dz2_q * cfg_i.bz;
      pc3_q[0] <= dy2_q * cfg_i.nz;
      pc3_q[1] <= dz2_q * cfg_i.ny;
      pc3_q[2] <= dz2_q * cfg_i.nx;
      pc3_q[3] <= dx2_q * cfg_i.nz;
      pc3_q[4] <= dx2_q * cfg_i.ny;
      pc3_q[5] <= dy2_q * cfg_i.nx;

      dot4_q <= sia_pkg::DOT_W'(pn3_q[0]) + sia_pkg::DOT_W'(pn3_q[1])
              + sia_pkg::DOT_W'(pn3_q[2]);
      fx4_q  <= sia_pkg::CORD_W'(pa3_q[0]) + sia_pkg::CORD_W'(pa3_q[1])
              + sia_pkg::CORD_W'(pa3_q[2]);
      fy4_q  <= sia_pkg::CORD_W'(pb3_q[0]) + sia_pkg::CORD_W'(pb3_q[1])
              + sia_pkg::CORD_W'(pb3_q[2]);
      c4_q[0] <= sia_pkg::C_W'(pc3_q[0]) - sia_pkg::C_W'(pc3_q[1]);
      c4_q[1] <= sia_pkg::C_W'(pc3_q[2]) - sia_pkg::C_W'(pc3_q[3]);
      c4_q[2] <= sia_pkg::C_W'(pc3_q[4]) - sia_pkg::C_W'(pc3_q[5]);

      // node strictly on the normal's side
      pos_q[0] <= !dot4_q[sia_pkg::DOT_W-1] && (dot4_q != '0);
      dm5_q    <= dot4_q;
      for (int j = 0; j < 3; j++) begin
        cm5_q[j] <= c4_q[j][sia_pkg::C_W-1] ? -c4_q[j] : c4_q[j];
      end

      m6_q  <= (m_a > m_b) ? m_a : m_b;
      cm6_q <= cm5_q;
      dm6_q <= dm5_q;

      s7_q  <= s_c;
      cm7_q <= cm6_q;
      dm7_q <= dm6_q;

      for (int j = 0; j < 3; j++) u8_q[j] <= sia_pkg::U_W'(cm7_q[j] >> s7_q);
      xs_q[0] <= sia_pkg::U_W'(dm7_q >> s7_q);

      for (int j = 0; j < 3; j++) sq9_q[j] <= u8_q[j] * u8_q[j];

      sv_q[0] <= sia_pkg::SQ_W'(sq9_q[0]) + sia_pkg::SQ_W'(sq9_q[1])
               + sia_pkg::SQ_W'(sq9_q[2]);
      sr_q[0] <= '0;
      for (int k = 0; k < NS; k++) begin
        sv_q[k+1] <= sv_d[k];
        sr_q[k+1] <= sr_d[k];
      end

      for (int k = 1; k <= XS_LEN; k++)  xs_q[k]  <= xs_q[k-1];
      for (int k = 1; k <= POS_LEN; k++) pos_q[k] <= pos_q[k-1];
      az_q[0] <= az_ang;
      for (int k = 1; k <= AZ_LEN; k++)  az_q[k]  <= az_q[k-1];
    end
  end

  sia_cordic u_az_cordic (
    .clk_i   (clk_i),
    .en_i    (adv),
    .xv_i    (fx4_q),
    .yv_i    (fy4_q),
    .angle_o (az_ang)
  );

  assign inc_x = sia_pkg::CORD_W'(xs_q[XS_LEN]);
  assign inc_y = sia_pkg::CORD_W'(sr_q[NS][sia_pkg::RES_W-1:0]);

  sia_cordic u_inc_cordic (
    .clk_i   (clk_i),
    .en_i    (adv),
    .xv_i    (inc_x),
    .yv_i    (inc_y),
    .angle_o (inc_ang)
  );

  // back side or at the surface gives zero angles
  always_comb begin
    res_d.valid_res = pos_q[POS_LEN];
    if (pos_q[POS_LEN]) begin
      res_d.azimuth     = az_q[AZ_LEN];
      res_d.inclination = inc_ang[sia_pkg::INC_W-1:0];
    end else begin
      res_d.azimuth     = '0;
      res_d.inclination = '0;
    end
  end

  assign oq_push     = adv && vld_q[LAST];
  assign res_empty_o = (oq_cnt_q == '0);
  assign oq_pop      = res_pop_i && !res_empty_o;
  assign res_o       = oq_q[oq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) oq_wr_q <= oq_wr_q + 1'b1;
      if (oq_pop)  oq_rd_q <= oq_rd_q + 1'b1;
      oq_cnt_q <= oq_cnt_q + (sia_pkg::OQ_AW+1)'(oq_push) - (sia_pkg::OQ_AW+1)'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) oq_q[oq_wr_q] <= res_d;
  end

endmodule

### hw/rtl/surface_incidence_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_incidence_angles: direction of a node seen from a reflecting surface
// azimuth and inclination of node minus surface in the frame of the normal
// ----------------------------------------------------------------------------
// Node positions enter through a queue-style port: an item is taken on a clock
// edge with push high and full low. Results leave the same way: the oldest
// result sits on valid_res_o, azimuth_o and inclination_o while empty is low
// and is taken on an edge with pop high. Every item gives exactly one result,
// in order. Surface position and normal are apb registers at 4*index; write
// them only while no item is in flight.
// From accept to empty going low an item passes through the products and sums,
// magnitude scaling and squaring, 31 square root stages and an 18 stage cordic
// (16 rotations). One item per cycle is accepted and returned
// as long as results are popped.
// When pop stays low the datapath freezes once the two-entry result queue is
// full; the four-entry input queue then fills and raises full.
// Reset empties both queues and sets the surface to the origin and the normal
// to +x.
// ----------------------------------------------------------------------------
module surface_incidence_angles (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [sia_pkg::NODE_W-1:0]    node_x_i,
  input  logic signed [sia_pkg::NODE_W-1:0]    node_y_i,
  input  logic signed [sia_pkg::NODE_W-1:0]    node_z_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 valid_res_o,
  output logic signed [sia_pkg::ANG_W-1:0]     azimuth_o,
  output logic [sia_pkg::INC_W-1:0]            inclination_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sia_pkg::APB_AW-1:0]           paddr,
  input  logic [sia_pkg::APB_DW-1:0]           pwdata,
  output logic [sia_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready
);

  sia_pkg::cfg_t  cfg;
  sia_pkg::node_t node_in, q_head;
  sia_pkg::res_t  res;
  logic           q_empty, q_pop;

  assign pready  = 1'b1;
  assign node_in = '{x: node_x_i, y: node_y_i, z: node_z_i};

  sia_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  sia_intake u_intake (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .node_i  (node_in),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  sia_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  assign valid_res_o   = res.valid_res;
  assign azimuth_o     = res.azimuth;
  assign inclination_o = res.inclination;

  a_back_side_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !valid_res_o) |-> (azimuth_o == '0 && inclination_o == '0))
    else $error("back side item with nonzero angles");

  a_incl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (inclination_o <= sia_pkg::INC_W'(sia_pkg::INC_MAX)))
    else $error("inclination beyond pi/2");

  a_azim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (azimuth_o <= sia_pkg::ANG_W'(sia_pkg::ANG_MAX)
                && azimuth_o >= -sia_pkg::ANG_W'(sia_pkg::ANG_MAX)))
    else $error("azimuth beyond pi");

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("back end pops an empty input queue");

endmodule

### tb/surface_incidence_angles_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_incidence_angles_tb: self-checking regression of the incidence block
// Node positions go in through the queue port with random bursts and gaps,
// surface and normal are set over apb between phases, and every result is
// compared field by field against a fixed-point angle predictor kept here.
// ----------------------------------------------------------------------------
module surface_incidence_angles_tb;

  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES  = 300;
  localparam longint ATAN_TAB [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              push;
  logic                              full;
  logic signed [sia_pkg::NODE_W-1:0] node_x_i, node_y_i, node_z_i;
  logic                              empty;
  logic                              pop;
  logic                              valid_res_o;
  logic signed [sia_pkg::ANG_W-1:0]  azimuth_o;
  logic [sia_pkg::INC_W-1:0]         inclination_o;
  logic                              psel, penable, pwrite;
  logic [sia_pkg::APB_AW-1:0]        paddr;
  logic [sia_pkg::APB_DW-1:0]        pwdata;
  logic [sia_pkg::APB_DW-1:0]        prdata;
  logic                              pready;

  surface_incidence_angles uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .node_x_i(node_x_i), .node_y_i(node_y_i), .node_z_i(node_z_i),
    .empty(empty), .pop(pop),
    .valid_res_o(valid_res_o), .azimuth_o(azimuth_o), .inclination_o(inclination_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // local copy of the registers
  longint surf_x, surf_y, surf_z, nrm_x, nrm_y, nrm_z;

  sia_pkg::res_t angle_q[$];
  int   mismatch_cnt;
  int   node_cnt, result_cnt, valid_cnt, setting_cnt;
  int   stall_pct = 25;
  int   burst_left;
  bit   no_gaps;
  bit   hold_on = 1'b0;
  event hold_ev;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2500000;
    $display("timeout with %0d results outstanding", angle_q.size());
    $display("Regression FAIL");
    $finish;
  end

  // long receiver hold, counted here
  initial begin
    forever begin
      @(hold_ev);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  function automatic longint unsigned mag_of(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // vectoring cordic on (|x|, |y|), quadrant restored afterwards, Q3.13 out
  function automatic longint cordic_atan2(longint yv, longint xv);
    longint x, y, z, dx, dy, q;
    int     steps;
    if (yv == 0 && xv == 0) return 0;
    steps = (sia_pkg::ANGLE_ITERATIONS > 24) ? 24 : sia_pkg::ANGLE_ITERATIONS;
    x = (xv < 0) ? -xv : xv;
    y = (yv < 0) ? -yv : yv;
    z = 0;
    for (int i = 0; i < steps; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x = x + dy; y = y - dx; z = z + ATAN_TAB[i];
      end else begin
        x = x - dy; y = y + dx; z = z - ATAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(sia_pkg::HALF_PI_Q24)) z = sia_pkg::HALF_PI_Q24;
    if (xv < 0) z = longint'(sia_pkg::PI_Q24) - z;
    q = (z + longint'(sia_pkg::ROUND_Q24)) >>> sia_pkg::Q_SHIFT;
    return (yv < 0) ? -q : q;
  endfunction

  function automatic sia_pkg::res_t predict_angles(logic signed [sia_pkg::NODE_W-1:0] px,
                                                   logic signed [sia_pkg::NODE_W-1:0] py,
                                                   logic signed [sia_pkg::NODE_W-1:0] pz);
    longint dx, dy, dz, dotn, ax, ay, az, bx, by, bz, fx, fy, cx, cy, cz;
    longint azim, incl;
    longint unsigned m, ux, uy, uz, sum;
    int s;
    sia_pkg::res_t r;
    r  = '0;
    dx = longint'(px) - surf_x;
    dy = longint'(py) - surf_y;
    dz = longint'(pz) - surf_z;
    dotn = dx * nrm_x + dy * nrm_y + dz * nrm_z;
    if (dotn <= 0) return r;
    if (mag_of(nrm_z) > longint'(sia_pkg::REF_SWITCH)) begin
      ax = 0; ay = -nrm_z; az = nrm_y;
    end else begin
      ax = -nrm_y; ay = nrm_x; az = 0;
    end
    bx = nrm_y * az - nrm_z * ay;
    by = nrm_z * ax - nrm_x * az;
    bz = nrm_x * ay - nrm_y * ax;
    fx = dx * ax + dy * ay + dz * az;
    fy = dx * bx + dy * by + dz * bz;
    azim = cordic_atan2(fy, fx);
    cx = dy * nrm_z - dz * nrm_y;
    cy = dz * nrm_x - dx * nrm_z;
    cz = dx * nrm_y - dy * nrm_x;
    m = dotn;
    if (mag_of(cx) > m) m = mag_of(cx);
    if (mag_of(cy) > m) m = mag_of(cy);
    if (mag_of(cz) > m) m = mag_of(cz);
    s = 0;
    while ((m >> s) >= (64'd1 << 30)) s++;
    ux  = mag_of(cx) >> s;
    uy  = mag_of(cy) >> s;
    uz  = mag_of(cz) >> s;
    sum = ux * ux + uy * uy + uz * uz;
    incl = cordic_atan2(longint'(floor_sqrt(sum)), dotn >>> s);
    r.valid_res   = 1'b1;
    r.azimuth     = azim[sia_pkg::ANG_W-1:0];
    r.inclination = incl[sia_pkg::INC_W-1:0];
    return r;
  endfunction

  // result checker and receiver stall pattern
  always @(posedge clk_i) begin
    sia_pkg::res_t want, got;
    if (rst_ni && pop && !empty) begin
      got = '{valid_res_o, azimuth_o, inclination_o};
      result_cnt++;
      if (angle_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", got);
      end else begin
        want = angle_q.pop_front();
        if (got.valid_res) valid_cnt++;
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: valid %0b/%0b azimuth %0d/%0d inclination %0d/%0d (exp/act)",
                     want.valid_res, got.valid_res, want.azimuth, got.azimuth,
                     want.inclination, got.inclination);
        end
      end
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_on) begin
      pop <= 1'b0;
    end else begin
      if ($urandom_range(199) == 0) stall_pct <= $urandom_range(3) * 25;
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic apb_write(sia_pkg::cfg_reg_e r, logic [sia_pkg::APB_DW-1:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= sia_pkg::APB_AW'(4 * int'(r)); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      sia_pkg::REG_SURFACE_X: surf_x = longint'($signed(v[sia_pkg::NODE_W-1:0]));
      sia_pkg::REG_SURFACE_Y: surf_y = longint'($signed(v[sia_pkg::NODE_W-1:0]));
      sia_pkg::REG_SURFACE_Z: surf_z = longint'($signed(v[sia_pkg::NODE_W-1:0]));
      sia_pkg::REG_NORMAL_X:  nrm_x  = longint'($signed(v[sia_pkg::NRM_W-1:0]));
      sia_pkg::REG_NORMAL_Y:  nrm_y  = longint'($signed(v[sia_pkg::NRM_W-1:0]));
      sia_pkg::REG_NORMAL_Z:  nrm_z  = longint'($signed(v[sia_pkg::NRM_W-1:0]));
      default: ;
    endcase
  endtask

  task automatic set_surface(int sx, int sy, int sz, int nx, int ny, int nz);
    apb_write(sia_pkg::REG_SURFACE_X, sx);
    apb_write(sia_pkg::REG_SURFACE_Y, sy);
    apb_write(sia_pkg::REG_SURFACE_Z, sz);
    apb_write(sia_pkg::REG_NORMAL_X, nx);
    apb_write(sia_pkg::REG_NORMAL_Y, ny);
    apb_write(sia_pkg::REG_NORMAL_Z, nz);
    setting_cnt++;
  endtask

  // returns in the step of acceptance with push still high
  task automatic send_node(int x, int y, int z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    node_x_i <= x[sia_pkg::NODE_W-1:0];
    node_y_i <= y[sia_pkg::NODE_W-1:0];
    node_z_i <= z[sia_pkg::NODE_W-1:0];
    do @(posedge clk_i); while (full);
    angle_q.push_back(predict_angles(node_x_i, node_y_i, node_z_i));
    node_cnt++;
  endtask

  task automatic drain();
    push <= 1'b0;
    while (angle_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int rand_pos();
    return $urandom_range(3) == 0 ? $urandom_range(0, 511) - 256 : int'($urandom());
  endfunction

  // node near the surface most of the time so the angles span their range
  task automatic send_random_node();
    int x, y, z;
    if ($urandom_range(3) == 0) begin
      x = rand_pos(); y = rand_pos(); z = rand_pos();
    end else begin
      x = int'(surf_x) + $signed($urandom()) / (1 << $urandom_range(0, 20));
      y = int'(surf_y) + $signed($urandom()) / (1 << $urandom_range(0, 20));
      z = int'(surf_z) + $signed($urandom()) / (1 << $urandom_range(0, 20));
    end
    send_node(x, y, z);
  endtask

  task automatic test_directed();
    set_surface(0, 0, 0, 16384, 0, 0);
    send_node(0, 0, 0);                              // at the surface
    send_node(8388607, 0, 0);
    send_node(-8388608, 0, 0);                       // back side
    send_node(8388607, 8388607, 8388607);
    send_node(8388607, -8388608, -8388608);
    send_node(1, 0, 0);
    send_node(1, -8388608, 0);
    send_node(0, 5, 5);                              // in the plane
    drain();
    // normal near z picks the x reference
    set_surface(-8388608, 8388607, -8388608, 0, 0, -16384);
    send_node(0, 0, -8388608);
    send_node(8388607, -8388608, 8388607);
    send_node(-8388608, 8388607, -8388609);
    drain();
    // normal parallel to the z reference, frame collapses
    set_surface(0, 0, 0, 0, 0, 1000);
    send_node(0, 0, 100);
    send_node(37, -12, 100);
    drain();
    // non-unit and zero normals, sign extension of wide writes
    set_surface(8388607, -1, 32'hFF80_0000, 32'h0000_8000, 32'h0001_7FFF, 3);
    send_node(0, 0, 0);
    send_node(-8388608, 100, -8388608);
    send_node(8388607, 0, 0);
    drain();
    set_surface(0, 0, 0, 0, 0, 0);
    send_node(1000, 2000, 3000);
    send_node(-5, -5, -5);
    drain();
    set_surface(100, 100, 100, 11585, 0, 11585);
    send_node(200, 200, 200);
    send_node(100, 300, 100);
    send_node(0, 0, 0);
    drain();
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(4))
        0: set_surface(rand_pos(), rand_pos(), rand_pos(), $urandom(), $urandom(),
                       $urandom());
        1: set_surface(rand_pos(), rand_pos(), rand_pos(), $urandom_range(32768) - 16384,
                       $urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
        2: set_surface(rand_pos(), rand_pos(), rand_pos(), $urandom_range(6000) - 3000,
                       $urandom_range(6000) - 3000, 14745 + $urandom_range(2));
        3: set_surface(rand_pos(), rand_pos(), rand_pos(), 0, 0,
                       $urandom_range(1) ? 16384 : -16384);
        default: set_surface(rand_pos(), rand_pos(), rand_pos(), $urandom_range(16384),
                             -16384 + $urandom_range(16384), $urandom_range(3000));
      endcase
      no_gaps = ($urandom_range(3) == 0);
      repeat (per_phase) send_random_node();
      no_gaps = 1'b0;
      drain();
    end
  endtask

  // more items than the pipeline and both queues hold, so full must rise
  task automatic test_backpressure();
    set_surface(0, 0, 0, 0, 16384, 0);
    -> hold_ev;
    no_gaps = 1'b1;
    repeat (120) send_random_node();
    no_gaps = 1'b0;
    drain();
  endtask

  task automatic test_pause();
    set_surface(rand_pos(), rand_pos(), rand_pos(), -16384, 0, 0);
    repeat (30) send_random_node();
    push <= 1'b0;
    while (angle_q.size() > 0) @(posedge clk_i);
    repeat (30) send_random_node();
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    node_x_i = '0; node_y_i = '0; node_z_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    surf_x = 0; surf_y = 0; surf_z = 0; nrm_x = 16384; nrm_y = 0; nrm_z = 0;
    mismatch_cnt = 0; node_cnt = 0; result_cnt = 0; valid_cnt = 0; setting_cnt = 0;
    burst_left = 0; no_gaps = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random_settings(12, 140);
    test_pause();

    $display("%0d nodes, %0d results (%0d front side) over %0d surface settings",
             node_cnt, result_cnt, valid_cnt, setting_cnt);
    $display("%0d mismatches", mismatch_cnt);
    if (mismatch_cnt == 0 && angle_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
